[sv/atp_pkg.sv]
`timescale 1ns / 1ps
package atp_pkg;

	// default coordinate width
	localparam int ATP_COORD_WIDTH = 16;

	// quotient bits of min/max ratio, Q0.16 plus the equal-magnitude bit
	localparam int ATP_QW = 17;

	// polynomial coefficients, Q0.16
	localparam logic [15:0] COEF_C3 = 16'd3047;
	localparam logic [15:0] COEF_C2 = 16'd10441;
	localparam logic [15:0] COEF_C1 = 16'd21471;

	// reflection constants, Q3.13
	localparam logic [15:0] HALFPI_Q13 = 16'd12868;
	localparam logic [15:0] PI_Q13     = 16'd25736;

	// classification carried alongside each item
	typedef struct packed {
		logic zero;
		logic swap;
		logic xneg;
		logic yneg;
	} atp_flags_t;

endpackage

[sv/atp_front.sv]
`timescale 1ns / 1ps
module atp_front import atp_pkg::*; #(
	parameter int COORD_WIDTH = ATP_COORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   q_full,
	input  logic [COORD_WIDTH-1:0] coord_x,
	input  logic [COORD_WIDTH-1:0] coord_y,
	output logic                   busy,
	output logic                   push,
	output logic [COORD_WIDTH-1:0] mn,
	output logic [COORD_WIDTH-1:0] mx,
	output atp_flags_t             flags
);

	logic                   accept;
	logic [COORD_WIDTH-1:0] ax, ay;
	logic                   valid_q;
	logic [COORD_WIDTH-1:0] mn_q, mx_q;
	atp_flags_t             fl_q;

	assign busy   = q_full;
	assign accept = start & ~q_full;

	// magnitudes; the most negative value maps to 2^(W-1), which fits unsigned
	assign ax = coord_x[COORD_WIDTH-1] ? (~coord_x + 1'b1) : coord_x;
	assign ay = coord_y[COORD_WIDTH-1] ? (~coord_y + 1'b1) : coord_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= accept;
		end
	end

	// min/max and octant flags
	always_ff @(posedge clk) begin
		if (accept) begin
			mn_q         <= (ax < ay) ? ax : ay;
			mx_q         <= (ax > ay) ? ax : ay;
			fl_q.zero    <= (ax == '0) && (ay == '0);
			fl_q.swap    <= ay > ax;
			fl_q.xneg    <= coord_x[COORD_WIDTH-1];
			fl_q.yneg    <= coord_y[COORD_WIDTH-1];
		end
	end

	assign push  = valid_q;
	assign mn    = mn_q;
	assign mx    = mx_q;
	assign flags = fl_q;

endmodule

[sv/atp_fifo.sv]
`timescale 1ns / 1ps
module atp_fifo #(
	parameter int DW = 36
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          full,
	output logic          out_valid,
	output logic [DW-1:0] dout
);

	logic [DW-1:0] mem_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          pop;

	// back end takes an item every cycle one is present
	assign pop       = count_q != 2'd0;
	assign out_valid = pop;
	assign full      = count_q == 2'd2;
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1 && !push) |=> count_q == 2'd0) else $error("queue did not drain");

endmodule

[sv/atp_div.sv]
`timescale 1ns / 1ps
module atp_div import atp_pkg::*; #(
	parameter int COORD_WIDTH = ATP_COORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [COORD_WIDTH-1:0] mn,
	input  logic [COORD_WIDTH-1:0] mx,
	input  atp_flags_t             in_flags,
	output logic                   out_valid,
	output logic [ATP_QW-1:0]      ratio,
	output atp_flags_t             out_flags
);

	localparam int W = COORD_WIDTH;

	logic [W-1:0]      rem_s [ATP_QW];
	logic [W-1:0]      mx_s  [ATP_QW];
	logic [ATP_QW-1:0] q_s   [ATP_QW];
	atp_flags_t        fl_s  [ATP_QW];
	logic              vld_s [ATP_QW];

	// restoring divider, one quotient bit per stage, MSB first
	for (genvar k = 0; k < ATP_QW; k++) begin : g_st
		logic [W:0]        rin;
		logic [W-1:0]      mxi;
		logic [ATP_QW-1:0] qi;
		atp_flags_t        fi;
		logic              vi;
		logic              ge;
		logic [W:0]        diff;

		if (k == 0) begin : g_first
			assign rin = {1'b0, mn};
			assign mxi = mx;
			assign qi  = '0;
			assign fi  = in_flags;
			assign vi  = in_valid;
		end else begin : g_next
			assign rin = {rem_s[k-1], 1'b0};
			assign mxi = mx_s[k-1];
			assign qi  = q_s[k-1];
			assign fi  = fl_s[k-1];
			assign vi  = vld_s[k-1];
		end

		assign ge   = rin >= {1'b0, mxi};
		assign diff = rin - {1'b0, mxi};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vi;
			end
		end

		// remainder stays below the divisor, so W bits hold it
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[W-1:0] : rin[W-1:0];
			mx_s[k]  <= mxi;
			q_s[k]   <= {qi[ATP_QW-2:0], ge};
			fl_s[k]  <= fi;
		end
	end

	assign out_valid = vld_s[ATP_QW-1];
	assign ratio     = q_s[ATP_QW-1];
	assign out_flags = fl_s[ATP_QW-1];

endmodule

[sv/atp_poly.sv]
`timescale 1ns / 1ps
module atp_poly import atp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [ATP_QW-1:0] ratio,
	input  atp_flags_t        in_flags,
	output logic              done,
	output logic [15:0]       angle
);

	logic [33:0] p1;
	logic [29:0] p2;
	logic [30:0] p3;
	logic [31:0] p4;
	logic [33:0] p5;
	logic [17:0] rr;
	logic [13:0] r13;
	logic [15:0] v0, v1, v2, v3;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	atp_flags_t  fl_s1, fl_s2, fl_s3, fl_s4, fl_s5;
	logic [16:0] a_s1, a_s2, a_s3, a_s4;
	logic [16:0] s_s1, s_s2, s_s3;
	logic [13:0] u1_s2;
	logic [14:0] u2_s3;
	logic [14:0] u3_s4;
	logic [16:0] r_s5;
	logic [15:0] angle_s6;

	// one multiply per stage, each rounded at bit 16
	assign p1 = 34'(ratio) * 34'(ratio) + 34'd32768;
	assign p2 = 30'(COEF_C3) * 30'(s_s1) + 30'd32768;
	assign p3 = 31'(u1_s2) * 31'(s_s2) + 31'd32768;
	assign p4 = 32'(u2_s3) * 32'(s_s3) + 32'd32768;
	assign p5 = 34'(u3_s4) * 34'(a_s4) + 34'd32768;

	// round to Q3.13, then reflect into the full circle
	assign rr  = 18'(r_s5) + 18'd4;
	assign r13 = rr[16:3];
	assign v0  = {2'b00, r13};
	assign v1  = fl_s5.swap ? (HALFPI_Q13 - v0) : v0;
	assign v2  = fl_s5.xneg ? (PI_Q13 - v1) : v1;
	assign v3  = fl_s5.yneg ? (16'd0 - v2) : v2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// s = a^2
		s_s1  <= p1[32:16];
		a_s1  <= ratio;
		fl_s1 <= in_flags;
		// u1 = C2 - C3*s
		u1_s2 <= 14'(COEF_C2) - p2[29:16];
		s_s2  <= s_s1;
		a_s2  <= a_s1;
		fl_s2 <= fl_s1;
		// u2 = C1 - u1*s
		u2_s3 <= 15'(COEF_C1) - p3[30:16];
		s_s3  <= s_s2;
		a_s3  <= a_s2;
		fl_s3 <= fl_s2;
		// u3 = u2*s
		u3_s4 <= p4[30:16];
		a_s4  <= a_s3;
		fl_s4 <= fl_s3;
		// r = a - u3*a
		r_s5  <= a_s4 - p5[32:16];
		fl_s5 <= fl_s4;
		// both inputs zero give zero
		angle_s6 <= fl_s5.zero ? 16'd0 : v3;
	end

	assign done  = v_s6;
	assign angle = angle_s6;

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(angle) <= $signed(PI_Q13) && $signed(angle) >= -$signed(PI_Q13)))
		else $error("angle out of range");
	a_r13_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !fl_s5.zero) |-> r13 <= 14'd8192) else $error("octant angle too large");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && fl_s5.zero) |=> (done && angle == 16'd0)) else $error("zero input not zero");

endmodule

[sv/atan2_polynomial_approx.sv]
`timescale 1ns / 1ps
// Four-quadrant atan2(coord_y, coord_x) in Q3.13 radians (pi = 25736). An
// item is taken on any clock edge with start high and busy low; busy stays low
// in normal use, so a new pair can be started every cycle. Each result shows
// on angle for one cycle with done high. On the way from start to done the item
// passes 25 registers: one of classification, one queue slot, 17 in the
// pipelined divider (one quotient bit per stage) and six in the polynomial
// and reflection pipeline.
// The receiver cannot stall; results must be taken as they appear.
module atan2_polynomial_approx import atp_pkg::*; #(
	parameter int COORD_WIDTH = ATP_COORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_WIDTH-1:0] coord_x,
	input  logic [COORD_WIDTH-1:0] coord_y,
	output logic                   done,
	output logic [15:0]            angle
);

	localparam int FW = $bits(atp_flags_t);
	localparam int DW = 2 * COORD_WIDTH + FW;

	logic                   q_full, push, q_valid;
	logic [COORD_WIDTH-1:0] f_mn, f_mx;
	atp_flags_t             f_flags, q_flags, d_flags;
	logic [DW-1:0]          q_din, q_dout;
	logic                   d_valid;
	logic [ATP_QW-1:0]      d_ratio;

	// front: magnitudes, min/max, octant flags
	atp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .q_full(q_full),
		.coord_x(coord_x), .coord_y(coord_y), .busy(busy), .push(push),
		.mn(f_mn), .mx(f_mx), .flags(f_flags)
	);

	assign q_din = {f_mn, f_mx, f_flags};

	// queue between front and back
	atp_fifo #(.DW(DW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(q_din),
		.full(q_full), .out_valid(q_valid), .dout(q_dout)
	);

	assign q_flags = q_dout[FW-1:0];

	// back: ratio, then polynomial and reflection
	atp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid),
		.mn(q_dout[DW-1 -: COORD_WIDTH]), .mx(q_dout[FW +: COORD_WIDTH]),
		.in_flags(q_flags), .out_valid(d_valid), .ratio(d_ratio), .out_flags(d_flags)
	);

	atp_poly u_poly (
		.clk(clk), .arst_n(arst_n), .in_valid(d_valid), .ratio(d_ratio),
		.in_flags(d_flags), .done(done), .angle(angle)
	);

endmodule

[sim/atan2_polynomial_approx_tb.sv]
`timescale 1ns / 1ps
module atan2_polynomial_approx_tb;
	import atp_pkg::*;

	localparam int CW = ATP_COORD_WIDTH;
	localparam int LATENCY = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_RANDOM = 1800;

	// expected-angle store; predicts from each accepted pair
	class angle_scoreboard;
		logic [15:0] pending_angles[$];
		int errors;
		int checked;

		function logic [15:0] atan2_q13(logic [CW-1:0] x, logic [CW-1:0] y);
			logic [63:0] ax, ay, mn, mx, a, s, u1, u2, u3, r, r13;
			logic xneg, yneg;
			xneg = x[CW-1];
			yneg = y[CW-1];
			ax = xneg ? 64'((~x) + 1'b1) & ((64'd1 << CW) - 1) : 64'(x);
			ay = yneg ? 64'((~y) + 1'b1) & ((64'd1 << CW) - 1) : 64'(y);
			mn = (ax < ay) ? ax : ay;
			mx = (ax > ay) ? ax : ay;
			if (mx == 0)
				return 16'd0;
			a = (mn << 16) / mx;
			s = (a * a + 64'd32768) >> 16;
			u1 = 64'(COEF_C2) - ((64'(COEF_C3) * s + 64'd32768) >> 16);
			u2 = 64'(COEF_C1) - ((u1 * s + 64'd32768) >> 16);
			u3 = (u2 * s + 64'd32768) >> 16;
			r = a - ((u3 * a + 64'd32768) >> 16);
			r13 = (r + 64'd4) >> 3;
			if (ay > ax)
				r13 = 64'(HALFPI_Q13) - r13;
			if (xneg)
				r13 = 64'(PI_Q13) - r13;
			if (yneg)
				r13 = 64'd0 - r13;
			return r13[15:0];
		endfunction

		function void note_pair(logic [CW-1:0] x, logic [CW-1:0] y);
			pending_angles.push_back(atan2_q13(x, y));
		endfunction

		function void check_angle(logic [15:0] got);
			logic [15:0] want;
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected angle, expected none, actual %0d", $time,
					$signed(got));
				errors++;
				return;
			end
			want = pending_angles.pop_front();
			checked++;
			if (got !== want) begin
				$display("%0t: angle mismatch, expected %0d, actual %0d", $time,
					$signed(want), $signed(got));
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	logic [CW-1:0] coord_x, coord_y;
	logic [15:0] angle;
	angle_scoreboard sb;
	int idle_cycles;
	int n_sent;
	bit no_gaps;

	atan2_polynomial_approx dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coord_x(coord_x), .coord_y(coord_y), .done(done), .angle(angle)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// watchdog: cycles without any accepted item or result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("FAIL");
			$finish;
		end
	end

	// results are taken on every strobe
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_angle(angle);
	end

	// present one pair and hold it until accepted
	task automatic send_pair(logic [CW-1:0] x, logic [CW-1:0] y);
		int gap;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		do @(posedge clk); while (busy);
		sb.note_pair(x, y);
		n_sent++;
	endtask

	// uniform pairs in a quarter of cases, the rest near axes, diagonals or small values
	task automatic send_random_pair();
		logic [CW-1:0] x, y;
		x = $urandom;
		y = $urandom;
		case ($urandom_range(0, 7))
			0: y = x;
			1: y = -x;
			2: y = $urandom_range(0, 3) - 2;
			3: x = $urandom_range(0, 3) - 2;
			4: begin
				x = $urandom_range(0, 15) - 8;
				y = $urandom_range(0, 15) - 8;
			end
			5: y = x + $urandom_range(0, 2) - 1;
			default: ;
		endcase
		send_pair(x, y);
	endtask

	initial begin
		localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
		localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};
		sb = new();
		start = 1'b0;
		coord_x = '0;
		coord_y = '0;
		arst_n = 1'b0;
		idle_cycles = 0;
		n_sent = 0;
		no_gaps = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: both zero, axes, diagonals, extremes
		send_pair('0, '0);
		send_pair(MAXP, '0);
		send_pair(MINN, '0);
		send_pair('0, MAXP);
		send_pair('0, MINN);
		send_pair(-1, '0);
		send_pair(MAXP, MAXP);
		send_pair(MINN, MINN);
		send_pair(MINN, MAXP);
		send_pair(MAXP, MINN);
		send_pair(1, 1);
		send_pair(-1, -1);
		send_pair(1, -1);
		send_pair(-1, 1);
		send_pair(MAXP, 1);
		send_pair(1, MAXP);
		send_pair(MINN, 1);
		send_pair(MINN, -1);
		send_pair(-1, MINN);
		send_pair(MAXP, MAXP - 1);
		send_pair(MINN, MINN + 1);

		for (int i = 0; i < N_RANDOM; i++) begin
			no_gaps = (i > N_RANDOM * 4 / 5);
			send_random_pair();
		end
		start <= 1'b0;

		while (sb.pending_angles.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);

		$display("sent %0d coordinate pairs, checked %0d angles", n_sent, sb.checked);
		$display("covered zero, axis, diagonal, extreme and random quadrant pairs");
		if (sb.errors == 0 && sb.pending_angles.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[sim.f]
sv/atp_pkg.sv
sv/atp_front.sv
sv/atp_fifo.sv
sv/atp_div.sv
sv/atp_poly.sv
sv/atan2_polynomial_approx.sv
sim/atan2_polynomial_approx_tb.sv
